### hdl/pft_pkg.sv
`timescale 1ns / 1ps
package pft_pkg;

    localparam int POS_W          = 24;
    localparam int AXIS_W         = 24;
    localparam int OFF_W          = 24;
    localparam int TEX_W          = 32;
    localparam int POS_FRAC_BITS  = 8;
    localparam int AXIS_FRAC_BITS = 16;
    // product carries POS+AXIS fraction bits; result keeps POS fraction bits
    localparam int DROP_BITS      = POS_FRAC_BITS + AXIS_FRAC_BITS - POS_FRAC_BITS;
    localparam int PROD_W         = POS_W + AXIS_W;
    localparam int ACC_W          = PROD_W + 4;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // what the back end does with a queued vertex
    typedef enum logic [1:0] {
        KIND_ANCHOR,
        KIND_SECOND,
        KIND_EMIT
    } kind_t;

    typedef enum logic [1:0] {
        CORNER_ANCHOR = 2'd0,
        CORNER_PREV   = 2'd1,
        CORNER_CUR    = 2'd2
    } corner_t;

    typedef enum logic [1:0] {
        BK_FIRST,
        BK_SECOND,
        BK_THIRD
    } bk_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
    } pt_t;

    typedef struct packed {
        pt_t   pt;
        kind_t kind;
    } vtx_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

### hdl/pft_front.sv
`timescale 1ns / 1ps
module pft_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [pft_pkg::POS_W-1:0]       s_pos_x,
    input  logic signed [pft_pkg::POS_W-1:0]       s_pos_y,
    input  logic signed [pft_pkg::POS_W-1:0]       s_pos_z,
    input  logic signed [pft_pkg::AXIS_W-1:0]      s_s_axis_x,
    input  logic signed [pft_pkg::AXIS_W-1:0]      s_s_axis_y,
    input  logic signed [pft_pkg::AXIS_W-1:0]      s_s_axis_z,
    input  logic signed [pft_pkg::OFF_W-1:0]       s_s_offset,
    input  logic signed [pft_pkg::AXIS_W-1:0]      s_t_axis_x,
    input  logic signed [pft_pkg::AXIS_W-1:0]      s_t_axis_y,
    input  logic signed [pft_pkg::AXIS_W-1:0]      s_t_axis_z,
    input  logic signed [pft_pkg::OFF_W-1:0]       s_t_offset,
    input  logic                                   s_polygon_start,
    input  pft_pkg::q_stat_t                       q_stat,
    output logic                                   q_push,
    output pft_pkg::vtx_t                          q_data
);
    import pft_pkg::*;

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (DROP_BITS - 1);

    function automatic logic signed [TEX_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] sh;
        logic [ACC_W-TEX_W:0]    top;
        sh  = acc >>> DROP_BITS;
        top = sh[ACC_W-1:TEX_W-1];
        if ((&top) || !(|top)) begin
            round_sat = sh[TEX_W-1:0];
        end else if (sh[ACC_W-1]) begin
            round_sat = {1'b1, {(TEX_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(TEX_W-1){1'b1}}};
        end
    endfunction

    logic                     accept;
    logic [1:0]               seen_reg, seen_next;
    kind_t                    kind_in;
    logic [QCNT_W:0]          occupancy;

    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_s_reg [3];
    logic signed [PROD_W-1:0] prod_t_reg [3];
    logic signed [OFF_W-1:0]  off_s_reg, off_t_reg;
    logic signed [POS_W-1:0]  x1_reg, y1_reg, z1_reg;
    kind_t                    kind1_reg;

    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_u_reg, acc_v_reg;
    logic signed [POS_W-1:0]  x2_reg, y2_reg, z2_reg;
    kind_t                    kind2_reg;

    // reserve a queue slot for every word still in the pipe
    assign occupancy = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(v1_reg)
                     + (QCNT_W+1)'(v2_reg);
    assign s_ready   = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept    = s_valid && s_ready;

    always_comb begin
        seen_next = seen_reg;
        if (s_polygon_start || seen_reg == 2'd0) begin
            kind_in   = KIND_ANCHOR;
            seen_next = 2'd1;
        end else if (seen_reg == 2'd1) begin
            kind_in   = KIND_SECOND;
            seen_next = 2'd2;
        end else begin
            kind_in   = KIND_EMIT;
            seen_next = 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 2'd0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end else begin
            if (accept) begin
                seen_reg <= seen_next;
            end
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prod_s_reg[0] <= s_pos_x * s_s_axis_x;
            prod_s_reg[1] <= s_pos_y * s_s_axis_y;
            prod_s_reg[2] <= s_pos_z * s_s_axis_z;
            prod_t_reg[0] <= s_pos_x * s_t_axis_x;
            prod_t_reg[1] <= s_pos_y * s_t_axis_y;
            prod_t_reg[2] <= s_pos_z * s_t_axis_z;
            off_s_reg     <= s_s_offset;
            off_t_reg     <= s_t_offset;
            x1_reg        <= s_pos_x;
            y1_reg        <= s_pos_y;
            z1_reg        <= s_pos_z;
            kind1_reg     <= kind_in;
        end
        if (v1_reg) begin
            acc_u_reg <= ACC_W'(prod_s_reg[0]) + ACC_W'(prod_s_reg[1])
                       + ACC_W'(prod_s_reg[2]) + (ACC_W'(off_s_reg) <<< DROP_BITS)
                       + signed'(ROUND_HALF);
            acc_v_reg <= ACC_W'(prod_t_reg[0]) + ACC_W'(prod_t_reg[1])
                       + ACC_W'(prod_t_reg[2]) + (ACC_W'(off_t_reg) <<< DROP_BITS)
                       + signed'(ROUND_HALF);
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            kind2_reg <= kind1_reg;
        end
    end

    always_comb begin
        q_push       = v2_reg;
        q_data.pt.x  = x2_reg;
        q_data.pt.y  = y2_reg;
        q_data.pt.z  = z2_reg;
        q_data.pt.u  = round_sat(acc_u_reg);
        q_data.pt.v  = round_sat(acc_v_reg);
        q_data.kind  = kind2_reg;
    end

endmodule

### hdl/pft_queue.sv
`timescale 1ns / 1ps
module pft_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pft_pkg::vtx_t    push_data,
    input  logic             pop,
    output pft_pkg::vtx_t    head,
    output pft_pkg::q_stat_t stat
);
    import pft_pkg::*;

    vtx_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + QPTR_W'(1);
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

### hdl/pft_back.sv
`timescale 1ns / 1ps
module pft_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pft_pkg::q_stat_t                  q_stat,
    input  pft_pkg::vtx_t                     head,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pft_pkg::POS_W-1:0]  m_out_x,
    output logic signed [pft_pkg::POS_W-1:0]  m_out_y,
    output logic signed [pft_pkg::POS_W-1:0]  m_out_z,
    output logic signed [pft_pkg::TEX_W-1:0]  m_out_u,
    output logic signed [pft_pkg::TEX_W-1:0]  m_out_v,
    output logic [1:0]                        m_corner_index,
    output logic                              m_triangle_last
);
    import pft_pkg::*;

    bk_state_t state_reg, state_next;
    pt_t       anchor_reg, prev_reg, out_pt_reg;
    corner_t   corner_reg;
    logic      last_reg;
    logic      m_valid_reg, m_valid_next;

    logic      slot_free;
    logic      load_out;
    pt_t       out_pt_sel;
    corner_t   corner_sel;
    logic      set_anchor, set_prev;

    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        out_pt_sel = head.pt;
        corner_sel = CORNER_CUR;
        set_anchor = 1'b0;
        set_prev   = 1'b0;
        unique case (state_reg)
            BK_FIRST: begin
                if (!q_stat.empty) begin
                    unique case (head.kind)
                        KIND_ANCHOR: begin
                            set_anchor = 1'b1;
                            set_prev   = 1'b1;
                            pop        = 1'b1;
                        end
                        KIND_SECOND: begin
                            set_prev = 1'b1;
                            pop      = 1'b1;
                        end
                        KIND_EMIT: begin
                            // hold the word at the head until its own corner goes out
                            if (slot_free) begin
                                load_out   = 1'b1;
                                out_pt_sel = anchor_reg;
                                corner_sel = CORNER_ANCHOR;
                                state_next = BK_SECOND;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_SECOND: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    out_pt_sel = prev_reg;
                    corner_sel = CORNER_PREV;
                    state_next = BK_THIRD;
                end
            end
            BK_THIRD: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    corner_sel = CORNER_CUR;
                    set_prev   = 1'b1;
                    pop        = 1'b1;
                    state_next = BK_FIRST;
                end
            end
            default: begin
                state_next = BK_FIRST;
            end
        endcase

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (set_anchor) begin
            anchor_reg <= head.pt;
        end
        if (set_prev) begin
            prev_reg <= head.pt;
        end
        if (load_out) begin
            out_pt_reg <= out_pt_sel;
            corner_reg <= corner_sel;
            last_reg   <= (corner_sel == CORNER_CUR);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_x         = out_pt_reg.x;
    assign m_out_y         = out_pt_reg.y;
    assign m_out_z         = out_pt_reg.z;
    assign m_out_u         = out_pt_reg.u;
    assign m_out_v         = out_pt_reg.v;
    assign m_corner_index  = corner_reg;
    assign m_triangle_last = last_reg;

endmodule

### hdl/polygon_fan_texgen_top.sv
`timescale 1ns / 1ps
// Triangle fan assembly with planar texture coordinates.
// Input channel (s_valid/s_ready): one polygon vertex per word, with its
// Q16.8 position, the face's Q8.16 S and T axes, Q16.8 offsets and a
// polygon_start flag. Output channel (m_valid/m_ready): one triangle corner
// per word, in the order anchor, previous, current; the current corner
// carries m_triangle_last. The first two vertices of a polygon produce no
// words; each later vertex produces three.
// Path: a vertex accepted on s_* passes two multiply/add stages, a queue
// write and one output register before its first corner appears on m_*.
// Throughput: one corner word per cycle while m_ready stays high, paced by
// the single output register; each fan vertex yields three corner words.
// A four-entry queue between the texgen pipeline and the fan emitter lets the
// front keep accepting while the emitter drains; s_ready is low while the
// queue and the words in the pipeline together hold four.
// Reset (aresetn low, synchronous) empties the pipeline and queue, drops
// m_valid and closes any open polygon. When the receiver holds m_ready low
// the output word holds and the queue fills, then s_ready falls.
module polygon_fan_texgen_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pft_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [pft_pkg::POS_W-1:0]  s_pos_y,
    input  logic signed [pft_pkg::POS_W-1:0]  s_pos_z,
    input  logic signed [pft_pkg::AXIS_W-1:0] s_s_axis_x,
    input  logic signed [pft_pkg::AXIS_W-1:0] s_s_axis_y,
    input  logic signed [pft_pkg::AXIS_W-1:0] s_s_axis_z,
    input  logic signed [pft_pkg::OFF_W-1:0]  s_s_offset,
    input  logic signed [pft_pkg::AXIS_W-1:0] s_t_axis_x,
    input  logic signed [pft_pkg::AXIS_W-1:0] s_t_axis_y,
    input  logic signed [pft_pkg::AXIS_W-1:0] s_t_axis_z,
    input  logic signed [pft_pkg::OFF_W-1:0]  s_t_offset,
    input  logic                              s_polygon_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pft_pkg::POS_W-1:0]  m_out_x,
    output logic signed [pft_pkg::POS_W-1:0]  m_out_y,
    output logic signed [pft_pkg::POS_W-1:0]  m_out_z,
    output logic signed [pft_pkg::TEX_W-1:0]  m_out_u,
    output logic signed [pft_pkg::TEX_W-1:0]  m_out_v,
    output logic [1:0]                        m_corner_index,
    output logic                              m_triangle_last
);
    import pft_pkg::*;

    q_stat_t q_stat;
    logic    q_push, q_pop;
    vtx_t    q_wdata, q_head;

    pft_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_s_axis_x      (s_s_axis_x),
        .s_s_axis_y      (s_s_axis_y),
        .s_s_axis_z      (s_s_axis_z),
        .s_s_offset      (s_s_offset),
        .s_t_axis_x      (s_t_axis_x),
        .s_t_axis_y      (s_t_axis_y),
        .s_t_axis_z      (s_t_axis_z),
        .s_t_offset      (s_t_offset),
        .s_polygon_start (s_polygon_start),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_data          (q_wdata)
    );

    pft_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    pft_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .head            (q_head),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .m_out_u         (m_out_u),
        .m_out_v         (m_out_v),
        .m_corner_index  (m_corner_index),
        .m_triangle_last (m_triangle_last)
    );

endmodule
